// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files; the core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sitda_pkg.sv =====
// Shared constants, types and sizing functions for the integer-to-text block.
`default_nettype none

package sitda_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  // Input bits folded into the BCD register per conversion cycle
  localparam int BITS_PER_STEP   = 3;
  // Digit count width: holds up to 19 digits, the most at 64 bits
  localparam int DIG_CNT_W       = 5;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Sign and digit count of one converted number
  typedef struct packed {
    logic                 neg;
    logic [DIG_CNT_W-1:0] ndig;
  } text_ctl_t;

  // Decimal digits needed for a magnitude of up to 2^(width-1)
  function automatic int digits_for(input int width);
    return ((width - 1) * 30103) / 100000 + 1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii_core.sv =====
// Signed integer to decimal ASCII text.
// Input channel (in_valid/in_ready/value) takes one two's complement word of
// VALUE_WIDTH bits. Output channel (out_valid/out_ready/text_char/last) gives
// its decimal text, most significant first, one character per word: a '-'
// for negative values, then the digits with no leading zeros ("0" for zero).
// last marks the final character of each number.
// The converter folds 3 bits per cycle; the first character is valid after
// the converted number passes the queue write, emitter load and output
// register. The converter takes a new number only once the queue has taken
// its last result; the emitter gives one character per cycle while the
// receiver is ready, up to 11 per number at 32 bits. A two-entry queue
// sits between the two.
// When the receiver stalls, the output register holds its word, the emitter
// and queue fill, and in_ready drops once the converter has nowhere to go.
// Synchronous reset empties the queue and pipeline; no other state.
`default_nettype none
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_core
  import sitda_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [VALUE_WIDTH-1:0] value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  text_char,
  output logic                        last
);

  localparam int NUM_DIGITS = digits_for(VALUE_WIDTH);
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int Q_W        = $bits(text_ctl_t) + BCD_W;

  logic             f_valid;
  logic             f_ready;
  text_ctl_t        f_ctl;
  logic [BCD_W-1:0] f_bcd;
  logic             q_valid;
  logic             q_ready;
  logic [Q_W-1:0]   q_data;
  text_ctl_t        q_ctl;
  logic [BCD_W-1:0] q_bcd;
  logic             is_minus;
  logic             is_digit;
  logic             in_take;

  assign q_ctl = q_data[Q_W-1:BCD_W];
  assign q_bcd = q_data[BCD_W-1:0];

  sitda_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .done_valid(f_valid),
    .done_ready(f_ready),
    .done_ctl  (f_ctl),
    .done_bcd  (f_bcd)
  );

  sitda_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data ({f_ctl, f_bcd}),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_data)
  );

  sitda_back #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .ent_valid(q_valid),
    .ent_ready(q_ready),
    .ent_ctl  (q_ctl),
    .ent_bcd  (q_bcd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .text_char(text_char),
    .last     (last)
  );

  // Character classes and input handshake for the checks
  assign is_minus = (text_char == CHAR_MINUS);
  assign is_digit = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
  assign in_take  = in_valid && in_ready;

  // Checks
  `ASSERT_IMPLY(a_char_set, clk, rst, out_valid, is_minus || is_digit, "bad character")
  `ASSERT_IMPLY(a_sign_not_last, clk, rst, out_valid && last, !is_minus, "sign marked last")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_take, !in_ready, "ready after accept")

endmodule

`default_nettype wire

// ===== hdl/sitda_front.sv =====
// Front end: accepts a number, forms its magnitude and converts it to BCD.
`default_nettype none

module sitda_front
  import sitda_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int NUM_DIGITS = digits_for(VALUE_WIDTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [VALUE_WIDTH-1:0]    value,
  output logic                           done_valid,
  input  wire logic                      done_ready,
  output text_ctl_t                      done_ctl,
  output logic [4*NUM_DIGITS-1:0]        done_bcd
);

  localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W  = STEPS * BITS_PER_STEP;
  localparam int CNT_W  = $clog2(STEPS);
  localparam int BCD_W  = 4 * NUM_DIGITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_DONE
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     cnt;
  logic                 neg;
  logic [PAD_W-1:0]     mag;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_next;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                 load;
  logic [DIG_CNT_W-1:0] ndig;

  // Magnitude as unsigned; the most negative value maps to 2^(W-1)
  assign mag_in = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

  assign in_ready   = !rst && ((state == S_IDLE) || (state == S_DONE && done_ready));
  assign load       = in_valid && in_ready;
  assign done_valid = (state == S_DONE);

  // Shift-and-add-3, BITS_PER_STEP input bits per cycle, MSB first
  always_comb begin
    logic [BCD_W-1:0] acc;
    logic [3:0]       nib;
    acc = bcd;
    nib = '0;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        nib = acc[d*4 +: 4];
        if (nib >= 4'd5) begin
          acc[d*4 +: 4] = nib + 4'd3;
        end
      end
      acc = {acc[BCD_W-2:0], mag[PAD_W-1-b]};
    end
    bcd_next = acc;
  end

  // Digit count: position of the highest nonzero digit, at least one
  always_comb begin
    ndig = DIG_CNT_W'(1);
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        ndig = DIG_CNT_W'(d + 1);
      end
    end
  end

  assign done_ctl.neg  = neg;
  assign done_ctl.ndig = ndig;
  assign done_bcd      = bcd;

  // Conversion sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (load) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_ready) begin
            state <= load ? S_CONV : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (load) begin
        cnt <= '0;
        neg <= value[VALUE_WIDTH-1];
        mag <= PAD_W'(mag_in);
        bcd <= '0;
      end else if (state == S_CONV) begin
        mag <= mag << BITS_PER_STEP;
        bcd <= bcd_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sitda_queue.sv =====
// Two-entry queue between the converter and the character emitter.
`default_nettype none

module sitda_queue
  import sitda_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output logic [DATA_W-1:0]      rd_data
);

  logic [DATA_W-1:0] entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= wr_data;
        wr_ptr          <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sitda_back.sv =====
// Back end: emits sign and digits of one number as ASCII, one per cycle while the receiver is ready.
`default_nettype none

module sitda_back
  import sitda_pkg::*;
#(
  parameter int NUM_DIGITS = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    ent_valid,
  output logic                         ent_ready,
  input  wire text_ctl_t               ent_ctl,
  input  wire logic [4*NUM_DIGITS-1:0] ent_bcd,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [7:0]                   text_char,
  output logic                         last
);

  localparam int IDX_W = $clog2(NUM_DIGITS);

  logic                    cur_valid;
  logic                    cur_sign;
  logic [IDX_W-1:0]        cur_idx;
  logic [4*NUM_DIGITS-1:0] cur_bcd;
  logic                    adv;
  logic                    cur_last;
  logic [7:0]              ch;
  logic                    load;

  // Next character of the current number
  assign adv       = cur_valid && (!out_valid || out_ready);
  assign cur_last  = !cur_sign && (cur_idx == IDX_W'(0));
  assign ch        = cur_sign ? CHAR_MINUS : (CHAR_ZERO + {4'd0, cur_bcd[cur_idx*4 +: 4]});
  assign ent_ready = !cur_valid || (adv && cur_last);
  assign load      = ent_valid && ent_ready;

  // Current number and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        text_char <= ch;
        last      <= cur_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        cur_valid <= 1'b1;
        cur_sign  <= ent_ctl.neg;
        cur_idx   <= IDX_W'(ent_ctl.ndig - DIG_CNT_W'(1));
        cur_bcd   <= ent_bcd;
      end else if (adv) begin
        if (cur_sign) begin
          cur_sign <= 1'b0;
        end else if (cur_idx == IDX_W'(0)) begin
          cur_valid <= 1'b0;
        end else begin
          cur_idx <= cur_idx - IDX_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire
